[rtl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and hex helpers shared by the URI percent
// decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic [7:0] MIN_CODE_RESET = 8'd32;
	localparam logic [7:0] MAX_CODE_RESET = 8'd127;

	localparam int unsigned ADDR_W = 3;
	localparam logic REG_MIN_CODE = 1'b0;
	localparam logic REG_MAX_CODE = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Up to three result bytes caused by one input transaction.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
	} bundle_t;

	typedef enum logic [2:0] {
		HOLD_NONE  = 3'b001,
		HOLD_PCT   = 3'b010,
		HOLD_DIGIT = 3'b100
	} hold_state_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] v;
		if (b >= 8'h61) begin
			v = b - 8'h57;
		end else if (b >= 8'h41) begin
			v = b - 8'h37;
		end else begin
			v = b - 8'h30;
		end
		return v[3:0];
	endfunction

endpackage

[rtl/uri_percent_decoder.sv]
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming URL percent decoder with a configurable range of accepted codes.
// ----------------------------------------------------------------------------
// The block takes one encoded character per cycle unless the queue is full
// and returns decoded bytes in order. A character that yields one result
// passes at one per cycle while results are popped; a transaction that
// yields two or three results (a rejected escape, a flush at the end of a
// string) occupies the output register byte by byte, one per cycle while
// popped, and the queue of QUEUE_DEPTH bundles lets the input keep flowing.
// A held '%' or digit produces no result until its escape resolves. A result
// is registered in the queue and then in the output register.
module uri_percent_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  upd_pkg::in_item_t            in_item,
	output logic                         empty,
	input  logic                         pop,
	output upd_pkg::out_item_t           out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [upd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import upd_pkg::*;

	logic [7:0] min_code_q;
	logic [7:0] max_code_q;
	logic       cfg_wr;
	logic       q_full;
	logic       q_wr;
	logic       q_rd;
	logic       q_empty;
	bundle_t    q_wdata;
	bundle_t    q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_MIN_CODE: prdata = {24'd0, min_code_q};
			REG_MAX_CODE: prdata = {24'd0, max_code_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_q <= MIN_CODE_RESET;
			max_code_q <= MAX_CODE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MIN_CODE) begin
				min_code_q <= pwdata[7:0];
			end else begin
				max_code_q <= pwdata[7:0];
			end
		end
	end

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.min_code (min_code_q),
		.max_code (max_code_q),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.out_item (out_item),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

[rtl/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front
// Accepts input characters, tracks a held '%' and hex digit, and turns each
// transaction into a bundle of up to three result bytes for the queue.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  upd_pkg::in_item_t in_item,
	input  logic [7:0]      min_code,
	input  logic [7:0]      max_code,
	input  logic            q_full,
	output logic            q_wr,
	output upd_pkg::bundle_t q_wdata
);
	import upd_pkg::*;

	hold_state_t state_q;
	hold_state_t state_nxt;
	logic [7:0]  digit_q;
	logic [7:0]  digit_nxt;
	logic        accept;
	bundle_t     res;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_wr   = accept && (res.cnt != 2'd0);
	assign q_wdata = res;

	always_comb begin
		logic [7:0] b;
		logic [7:0] pb;
		logic [7:0] code;
		logic       pct;
		logic       hex;
		logic       in_range;
		b         = in_item.in_byte;
		pb        = (b == PLUS_CHAR) ? SPACE_CHAR : b;
		pct       = (b == PCT_CHAR);
		hex       = is_hex(b);
		code      = {hex_val(digit_q), hex_val(b)};
		in_range  = (code >= min_code) && (code <= max_code);
		res       = '0;
		state_nxt = state_q;
		digit_nxt = digit_q;
		unique case (state_q)
			HOLD_NONE: begin
				if (pct) begin
					state_nxt = HOLD_PCT;
				end else begin
					res.bytes[0] = pb;
					res.cnt      = 2'd1;
				end
			end
			HOLD_PCT: begin
				if (hex) begin
					state_nxt = HOLD_DIGIT;
					digit_nxt = b;
				end else begin
					res.bytes[0] = PCT_CHAR;
					if (pct) begin
						res.cnt = 2'd1;
					end else begin
						res.bytes[1] = pb;
						res.cnt      = 2'd2;
						state_nxt    = HOLD_NONE;
					end
				end
			end
			HOLD_DIGIT: begin
				state_nxt = HOLD_NONE;
				if (hex) begin
					if (in_range) begin
						res.bytes[0] = code;
						res.cnt      = 2'd1;
					end else begin
						res.bytes[0] = PCT_CHAR;
						res.bytes[1] = digit_q;
						res.bytes[2] = b;
						res.cnt      = 2'd3;
					end
				end else begin
					res.bytes[0] = PCT_CHAR;
					res.bytes[1] = digit_q;
					if (pct) begin
						res.cnt   = 2'd2;
						state_nxt = HOLD_PCT;
					end else begin
						res.bytes[2] = pb;
						res.cnt      = 2'd3;
					end
				end
			end
			default: begin
				state_nxt = HOLD_NONE;
			end
		endcase
		if (in_item.in_last) begin
			if (state_nxt == HOLD_PCT) begin
				res.bytes[res.cnt] = PCT_CHAR;
				res.cnt            = res.cnt + 2'd1;
			end else if (state_nxt == HOLD_DIGIT) begin
				res.bytes[0] = PCT_CHAR;
				res.bytes[1] = digit_nxt;
				res.cnt      = 2'd2;
			end
			state_nxt = HOLD_NONE;
			res.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HOLD_NONE;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			digit_q <= digit_nxt;
		end
	end

endmodule

[rtl/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of result bundles between the front and
// back parts of the decoder.
// ----------------------------------------------------------------------------
module upd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  upd_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output upd_pkg::bundle_t rd_data,
	output logic             empty
);
	import upd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bundle_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back
// Takes bundles from the queue and hands their bytes one at a time to the
// output register, marking the final byte of a string.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  upd_pkg::bundle_t  head,
	input  logic              q_empty,
	output logic              q_rd,
	output upd_pkg::out_item_t out_item,
	output logic              empty,
	input  logic              pop
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       at_end;

	assign load     = !q_empty && (!out_valid_q || pop);
	assign at_end   = (idx_q == head.cnt - 2'd1);
	assign q_rd     = load && at_end;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head.bytes[idx_q];
			out_q.out_last <= head.last && at_end;
		end
	end

endmodule

[rtl/upd_checker.sv]
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the URI percent decoder, attached by a bind.
// ----------------------------------------------------------------------------
module upd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input upd_pkg::out_item_t         out_item,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [upd_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready
);
	import upd_pkg::*;

	// A waiting result stays in place until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result changed or vanished while stalled");

	// During reset nothing is offered and input is open.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> empty && !full)
		else $error("queue flags wrong during reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	// A register read right after its write returns the written value.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr))
		|-> prdata[7:0] == $past(pwdata[7:0]))
		else $error("configuration readback mismatch");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (.*);
